// ----- rtl/pcpfa_pkg.sv -----
// Package for the per-CPU page-frame allocator: request/result types, codes, defaults.
// No dependencies.
`default_nettype none
package pcpfa_pkg;
  localparam int unsigned DefNumCpus    = 8;
  localparam int unsigned DefNumPages   = 32768;
  localparam int unsigned DefCountWidth = 16;

  typedef enum logic [2:0] {
    KIND_SEED   = 3'd0,
    KIND_ALLOC  = 3'd1,
    KIND_FREE   = 3'd2,
    KIND_INCREF = 3'd3,
    KIND_DECREF = 3'd4,
    KIND_GETREF = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_OOM   = 3'd1,
    ST_BAD   = 3'd2,
    ST_UNDER = 3'd3,
    ST_OVER  = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  cpu;
    logic [14:0] page;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [14:0] granted_page;
    logic [15:0] ref_value;
    logic        returned_to_list;
    logic [15:0] free_pages;
  } rsp_t;
endpackage
`default_nettype wire

// ----- rtl/pcpfa_link_mem.sv -----
// Next-page link memory: one write port, one registered read port.
// Depends on nothing; uninitialized contents.
`default_nettype none
module pcpfa_link_mem #(
  parameter int unsigned Depth = 32768,
  parameter int unsigned AddrW = 15
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [AddrW:0]   wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [AddrW:0]   rdata_o
);
  // entry = {valid, next page}
  logic [AddrW:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/pcpfa_ref_mem.sv -----
// Reference count memory with registered read and an epoch-free clear sweep.
// Clear sweep runs after reset; busy_o holds off requests meanwhile.
`default_nettype none
module pcpfa_ref_mem #(
  parameter int unsigned Depth  = 32768,
  parameter int unsigned AddrW  = 15,
  parameter int unsigned CountW = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire logic [CountW-1:0] wdata_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output      logic [CountW-1:0] rdata_o,
  output      logic              busy_o
);
  logic [CountW-1:0] mem [Depth];
  logic [AddrW:0]    clr_q, clr_d;
  logic              clr_done;

  assign clr_done = (clr_q == (AddrW+1)'(Depth));
  assign busy_o   = !clr_done;
  assign clr_d    = clr_done ? clr_q : clr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else         clr_q <= clr_d;
  end

  always_ff @(posedge clk_i) begin
    if (!clr_done)  mem[clr_q[AddrW-1:0]] <= '0;
    else if (we_i)  mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/per_cpu_page_frame_allocator_unit.sv -----
// Per-CPU page-frame allocator, top level.
// Each accepted request is read (S_RD), then written (S_WR); done_o is registered from S_WR.
// One request at a time; busy is high while one is in flight.
// After reset a clearing pass zeroes the count memory, with busy high meanwhile.
// Reset: all lists empty, counts zero, free total zero, first_usable_page 0.
// The receiver cannot stall: each result is shown with done_o for one cycle.
`default_nettype none
module per_cpu_page_frame_allocator_unit #(
  parameter int unsigned NUM_CPUS    = pcpfa_pkg::DefNumCpus,
  parameter int unsigned NUM_PAGES   = pcpfa_pkg::DefNumPages,
  parameter int unsigned COUNT_WIDTH = pcpfa_pkg::DefCountWidth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output      logic            busy,
  input  wire pcpfa_pkg::req_t req_i,
  output      logic            done_o,
  output      pcpfa_pkg::rsp_t rsp_o,
  input  wire logic            cfg_valid_i,
  output      logic            cfg_ready_o,
  input  wire logic [15:0]     cfg_data_i
);
  import pcpfa_pkg::*;

  localparam int unsigned AddrW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned CpuW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int unsigned CMax  = COUNT_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_WR   = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [15:0] first_q;
  logic [15:0] total_q, total_d;
  logic [AddrW-1:0] head_q [NUM_CPUS];
  logic [NUM_CPUS-1:0] hval_q;
  req_t req_q;
  logic [CpuW-1:0] cpu_q;
  rsp_t rsp_q;
  logic done_q;

  // pop target chosen at accept
  logic [CpuW-1:0] pop_sel_q, pop_sel_d;
  logic            pop_ok_q, pop_ok_d;
  logic [CpuW-1:0] cpu_in;
  // cpu field folded onto the list count: constant table, one entry per field code
  logic [CpuW-1:0] cpu_fold [8];

  logic ref_busy;
  logic [CMax-1:0] ref_rd;
  logic [AddrW:0]  link_rd;
  logic            ref_we, link_we;
  logic [AddrW-1:0] ref_wa, ref_ra, link_wa, link_ra;
  logic [CMax-1:0]  ref_wd;
  logic [AddrW:0]   link_wd;

  // page checks on the held request
  logic in_mem, usable;
  logic [AddrW-1:0] pg;
  logic [AddrW-1:0] pop_page;

  for (genvar g = 0; g < 8; g++) begin : g_cpu_fold
    assign cpu_fold[g] = CpuW'(g % NUM_CPUS);
  end

  assign cpu_in = cpu_fold[req_i.cpu];
  assign busy   = (state_q != S_IDLE) || ref_busy;
  assign cfg_ready_o = 1'b1;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign in_mem = 32'(req_q.page) < NUM_PAGES;
  assign usable = in_mem && ({1'b0, req_q.page} >= first_q);
  assign pg     = AddrW'(req_q.page);
  assign pop_page = head_q[pop_sel_q];

  // own list first, else lowest other non-empty list
  always_comb begin
    pop_ok_d  = hval_q[cpu_in];
    pop_sel_d = cpu_in;
    if (!hval_q[cpu_in]) begin
      for (int i = NUM_CPUS - 1; i >= 0; i--) begin
        if (hval_q[i]) begin
          pop_ok_d  = 1'b1;
          pop_sel_d = CpuW'(i);
        end
      end
    end
  end

  always_comb begin
    unique case (state_q)
      S_IDLE:  state_d = (start && !busy) ? S_RD : S_IDLE;
      S_RD:    state_d = S_WR;
      S_WR:    state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // memory read addresses during IDLE accept
  assign ref_ra  = AddrW'(req_i.page);
  assign link_ra = head_q[pop_sel_d];

  // write phase decisions
  logic push, pop;
  rsp_t r;
  always_comb begin
    r = '0;
    push = 1'b0; pop = 1'b0;
    ref_we = 1'b0; ref_wa = pg; ref_wd = '0;
    link_we = 1'b0; link_wa = pg;
    link_wd = {hval_q[cpu_q], head_q[cpu_q]};
    total_d = total_q;
    case (req_q.kind)
      KIND_SEED: begin
        if (!usable) r.status = ST_BAD;
        else begin
          ref_we = 1'b1; push = 1'b1;
          link_wd = {hval_q[0], head_q[0]};
        end
      end
      KIND_ALLOC: begin
        if (!pop_ok_q) r.status = ST_OOM;
        else begin
          pop = 1'b1; ref_we = 1'b1; ref_wa = pop_page; ref_wd = CMax'(1);
          r.granted_page = 15'(pop_page);
          r.ref_value = 16'd1;
        end
      end
      KIND_FREE: begin
        if (!usable) r.status = ST_BAD;
        else if (ref_rd == '0) r.status = ST_UNDER;
        else begin
          ref_we = 1'b1; ref_wd = ref_rd - 1'b1;
          r.ref_value = 16'(ref_wd);
          push = (ref_wd == '0);
        end
      end
      KIND_INCREF: begin
        if (!in_mem) r.status = ST_BAD;
        else if (ref_rd == '1) begin
          r.status = ST_OVER; r.ref_value = 16'(ref_rd);
        end else begin
          ref_we = 1'b1; ref_wd = ref_rd + 1'b1; r.ref_value = 16'(ref_wd);
        end
      end
      KIND_DECREF: begin
        if (!in_mem) r.status = ST_BAD;
        else if (ref_rd == '0) r.status = ST_UNDER;
        else begin
          ref_we = 1'b1; ref_wd = ref_rd - 1'b1; r.ref_value = 16'(ref_wd);
        end
      end
      KIND_GETREF: begin
        if (!in_mem) r.status = ST_BAD;
        else r.ref_value = 16'(ref_rd);
      end
      default: ;
    endcase
    link_we = push;
    if (push && total_q != 16'hFFFF) total_d = total_q + 1'b1;
    if (pop && total_q != 16'h0) total_d = total_q - 1'b1;
    r.returned_to_list = push;
    r.free_pages = total_d;
    if (state_q != S_WR) begin
      ref_we = 1'b0; link_we = 1'b0; total_d = total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      first_q <= '0;
      total_q <= '0;
      hval_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      done_q  <= (state_q == S_WR);
      if (cfg_valid_i) first_q <= cfg_data_i;
      if (state_q == S_WR) begin
        if (pop) hval_q[pop_sel_q] <= link_rd[AddrW];
        if (push) hval_q[(req_q.kind == KIND_SEED) ? '0 : cpu_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start && !busy) begin
      req_q     <= req_i;
      cpu_q     <= cpu_in;
      pop_sel_q <= pop_sel_d;
      pop_ok_q  <= pop_ok_d;
    end
    if (state_q == S_WR) begin
      rsp_q <= r;
      if (pop) head_q[pop_sel_q] <= link_rd[AddrW-1:0];
      if (push) head_q[(req_q.kind == KIND_SEED) ? '0 : cpu_q] <= pg;
    end
  end

  // link read data valid in S_RD; hold it into S_WR
  logic [AddrW:0] link_raw;
  logic [CMax-1:0] ref_raw;
  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      link_rd <= link_raw;
      ref_rd  <= ref_raw;
    end
  end

  pcpfa_link_mem #(.Depth(NUM_PAGES), .AddrW(AddrW)) u_link (
    .clk_i, .we_i(link_we), .waddr_i(link_wa), .wdata_i(link_wd),
    .raddr_i(link_ra), .rdata_o(link_raw)
  );

  pcpfa_ref_mem #(.Depth(NUM_PAGES), .AddrW(AddrW), .CountW(CMax)) u_ref (
    .clk_i, .rst_ni, .we_i(ref_we), .waddr_i(ref_wa), .wdata_i(ref_wd),
    .raddr_i(ref_ra), .rdata_o(ref_raw), .busy_o(ref_busy)
  );

  a_done_after_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |=> done_o) else $error("missing done");
  a_no_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> !(push && pop)) else $error("push and pop together");
  a_start_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 (state_q == S_WR)) else $error("sequence broken");
endmodule
`default_nettype wire

// ----- test/tb_per_cpu_page_frame_allocator_unit.sv -----
// Testbench for per_cpu_page_frame_allocator_unit: directed and random requests,
// checked against an in-bench allocator model. Depends on pcpfa_pkg and the RTL top.
`timescale 1ns / 100ps
module tb_per_cpu_page_frame_allocator_unit;
  import pcpfa_pkg::*;

  localparam int unsigned NumCpus  = DefNumCpus;
  localparam int unsigned NumPages = DefNumPages;
  localparam logic [15:0] CountMax = 16'hFFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        done_o;
  rsp_t        rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  per_cpu_page_frame_allocator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Allocator state as the bench sees it.
  logic [15:0] first_usable;
  logic [14:0] head_pg   [NumCpus];
  bit          head_ok   [NumCpus];
  logic [14:0] link_pg   [NumPages];
  bit          link_ok   [NumPages];
  logic [15:0] ref_cnt   [NumPages];
  logic [15:0] listed_total;

  rsp_t        pending_rsp[$];
  logic [14:0] held_pages[$];   // pages handed out by alloc, candidates for free
  bit          failed = 1'b0;
  int          burst_left = 0;

  function automatic void push_free(input int unsigned lst, input logic [14:0] pg);
    link_pg[pg]  = head_pg[lst];
    link_ok[pg]  = head_ok[lst];
    head_pg[lst] = pg;
    head_ok[lst] = 1'b1;
    if (listed_total != 16'hFFFF) listed_total++;
  endfunction

  function automatic bit pop_free(input int unsigned lst, output logic [14:0] pg);
    pg = '0;
    if (!head_ok[lst]) return 1'b0;
    pg           = head_pg[lst];
    head_pg[lst] = link_pg[pg];
    head_ok[lst] = link_ok[pg];
    if (listed_total != 0) listed_total--;
    return 1'b1;
  endfunction

  // Works out the result of one accepted request and updates the model state.
  function automatic rsp_t alloc_outcome(input req_t r);
    rsp_t        e;
    int unsigned cpu;
    bit          usable;
    bit          got;
    logic [14:0] pg;
    e      = '0;
    cpu    = r.cpu % NumCpus;
    usable = {1'b0, r.page} >= first_usable;
    case (r.kind)
      KIND_SEED: begin
        if (!usable) e.status = ST_BAD;
        else begin
          ref_cnt[r.page] = '0;
          push_free(0, r.page);
          e.returned_to_list = 1'b1;
        end
      end
      KIND_ALLOC: begin
        got = pop_free(cpu, pg);
        for (int c = 0; c < NumCpus && !got; c++)
          if (c != cpu) got = pop_free(c, pg);
        if (!got) e.status = ST_OOM;
        else begin
          ref_cnt[pg]    = 16'd1;
          e.granted_page = pg;
          e.ref_value    = 16'd1;
          if (held_pages.size() < 256) held_pages.push_back(pg);
        end
      end
      KIND_FREE: begin
        if (!usable) e.status = ST_BAD;
        else if (ref_cnt[r.page] == 0) e.status = ST_UNDER;
        else begin
          ref_cnt[r.page]--;
          e.ref_value = ref_cnt[r.page];
          if (ref_cnt[r.page] == 0) begin
            push_free(cpu, r.page);
            e.returned_to_list = 1'b1;
          end
        end
      end
      KIND_INCREF: begin
        if (ref_cnt[r.page] == CountMax) e.status = ST_OVER;
        else ref_cnt[r.page]++;
        e.ref_value = ref_cnt[r.page];
      end
      KIND_DECREF: begin
        if (ref_cnt[r.page] == 0) e.status = ST_UNDER;
        else ref_cnt[r.page]--;
        e.ref_value = ref_cnt[r.page];
      end
      KIND_GETREF: e.ref_value = ref_cnt[r.page];
      default: ;
    endcase
    e.free_pages = listed_total;
    return e;
  endfunction

  // Sends one item: start held from a falling edge until accepted at a rising edge.
  task automatic send_req(input logic [2:0] kind, input logic [2:0] cpu,
                          input logic [14:0] page);
    req_t r;
    r = '{kind: kind, cpu: cpu, page: page};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk_i);
        start <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    // busy only moves at rising edges, so its value here holds up to the next one
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    pending_rsp.push_back(alloc_outcome(r));
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // Register write; only called with nothing in flight.
  task automatic set_first_usable(input logic [15:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    first_usable = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Result checker: done_o sampled at the edge that ends its cycle.
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $error("result with no request outstanding");
        failed = 1'b1;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_o.status !== e.status) begin
          $error("status exp %0d act %0d", e.status, rsp_o.status); failed = 1'b1;
        end
        if (rsp_o.granted_page !== e.granted_page) begin
          $error("granted_page exp %0d act %0d", e.granted_page, rsp_o.granted_page);
          failed = 1'b1;
        end
        if (rsp_o.ref_value !== e.ref_value) begin
          $error("ref_value exp %0d act %0d", e.ref_value, rsp_o.ref_value); failed = 1'b1;
        end
        if (rsp_o.returned_to_list !== e.returned_to_list) begin
          $error("returned_to_list exp %0d act %0d", e.returned_to_list,
                 rsp_o.returned_to_list);
          failed = 1'b1;
        end
        if (rsp_o.free_pages !== e.free_pages) begin
          $error("free_pages exp %0d act %0d", e.free_pages, rsp_o.free_pages);
          failed = 1'b1;
        end
      end
    end
  end

  // Edge values of every field, all kinds including the unused codes, stealing,
  // out of memory, underflow on free and decref, double push.
  task automatic test_directed();
    send_req(KIND_GETREF, 3'd0, 15'd0);
    send_req(KIND_GETREF, 3'd7, 15'h7FFF);
    send_req(KIND_ALLOC, 3'd3, 15'h7FFF);      // nothing listed yet
    send_req(KIND_SEED, 3'd5, 15'd0);
    send_req(KIND_SEED, 3'd0, 15'h7FFF);
    send_req(KIND_SEED, 3'd2, 15'h5555);
    send_req(KIND_ALLOC, 3'd7, 15'd0);         // steals from list 0
    send_req(KIND_ALLOC, 3'd0, 15'h2AAA);
    send_req(KIND_FREE, 3'd5, 15'h7FFF);       // back onto list 5
    send_req(KIND_ALLOC, 3'd5, 15'd0);
    send_req(KIND_INCREF, 3'd1, 15'h7FFF);
    send_req(KIND_FREE, 3'd6, 15'h7FFF);       // count 2 -> 1, stays out
    send_req(KIND_DECREF, 3'd4, 15'h7FFF);     // reaches 0, no push
    send_req(KIND_DECREF, 3'd4, 15'h7FFF);     // underflow
    send_req(KIND_FREE, 3'd4, 15'h7FFF);       // underflow
    send_req(KIND_SEED, 3'd1, 15'h5555);       // double push
    send_req(3'd6, 3'd2, 15'h1234);
    send_req(3'd7, 3'd7, 15'h7FFF);
    send_req(KIND_ALLOC, 3'd2, 15'd0);
    send_req(KIND_ALLOC, 3'd1, 15'd0);
    send_req(KIND_ALLOC, 3'd6, 15'd0);
    send_req(KIND_ALLOC, 3'd6, 15'd0);         // out of memory
    send_req(KIND_GETREF, 3'd3, 15'h5555);
  endtask

  // Mostly well-formed traffic: seeds in a page window, allocs, frees of held
  // pages, count traffic on held pages; some random pages as noise.
  task automatic test_random(input int n_items, input logic [14:0] base);
    logic [2:0]  kind;
    logic [14:0] pg;
    int          sel;
    int          w;
    for (int i = 0; i < n_items; i++) begin
      w = $urandom_range(0, 99);
      if (held_pages.size() != 0) begin
        sel = $urandom_range(0, held_pages.size() - 1);
        pg  = held_pages[sel];
      end else pg = base + 15'($urandom_range(0, 63));
      if (w < 20) begin
        kind = KIND_SEED;
        pg   = base + 15'($urandom_range(0, 63));
      end else if (w < 45) kind = KIND_ALLOC;
      else if (w < 68) begin
        kind = KIND_FREE;
        if (held_pages.size() != 0 && ref_cnt[pg] <= 1) held_pages.delete(sel);
      end else if (w < 78) kind = KIND_INCREF;
      else if (w < 85) kind = KIND_DECREF;
      else if (w < 90) kind = KIND_GETREF;
      else begin
        kind = 3'($urandom_range(0, 7));
        pg   = 15'($urandom);
      end
      send_req(kind, 3'($urandom_range(0, 7)), pg);
    end
  endtask

  initial begin
    first_usable = '0;
    listed_total = '0;
    for (int c = 0; c < NumCpus; c++) begin
      head_pg[c] = '0;
      head_ok[c] = 1'b0;
    end
    for (int p = 0; p < NumPages; p++) begin
      link_pg[p] = '0;
      link_ok[p] = 1'b0;
      ref_cnt[p] = '0;
    end
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    set_first_usable(16'd32768);               // nothing may be seeded or freed
    test_random(200, 15'd100);
    set_first_usable(16'd100);
    test_random(450, 15'd100);
    set_first_usable(16'($urandom_range(1, 32700)));
    test_random(400, first_usable[14:0]);
    set_first_usable(16'd32767);               // only the top page is usable
    test_random(150, 15'h7FC0);
    set_first_usable(16'd0);
    test_random(450, 15'd0);

    drain();
    repeat (10) @(negedge clk_i);
    if (!failed) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #500_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/pcpfa_pkg.sv
rtl/pcpfa_link_mem.sv
rtl/pcpfa_ref_mem.sv
rtl/per_cpu_page_frame_allocator_unit.sv
test/tb_per_cpu_page_frame_allocator_unit.sv
